>>> rtl/core/dsb_pkg.sv
package dsb_pkg;

  // Field widths of the request and response payloads.
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned HZ_W    = 15;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned PHASE_W = 32;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd8000;
  localparam int unsigned      MS_PER_S  = 1000;

  // 2*pi in unsigned Q3.30.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e            command;
    logic [HZ_W-1:0] tone_hz;
    logic [MS_W-1:0] duration_ms;
  } req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    active;
    logic                    last;
  } rsp_t;

  // Quarter-wave sine magnitude scaled to 32768 and saturated, used only to
  // build the constant table at elaboration. Taylor series in Q2.30.
  function automatic logic [AMP_W-1:0] quarter_sine(int unsigned m, int unsigned table_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(m) * TWO_PI_Q30) >> table_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    // Terms up to x^17; the negative ones never take the sum below zero.
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    sum = ((sum << 15) + (64'd1 << 29)) >> 30;
    return (sum > 64'd32767) ? 15'h7FFF : sum[AMP_W-1:0];
  endfunction

endpackage

>>> rtl/core/dsb_stream_if.sv
interface dsb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/dds_sine_tone_burst.sv
// A tick request is registered into the request stage when accepted, and its
// sample is registered into the response stage once that stage has room.
// Throughput is one request per cycle while the response side is not
// stalled, set by the single pass through phase lookup and amplitude multiply.
// Reset (asynchronous, active low) clears the tone state, the pipeline valid
// flags, and loads the amplitude with 8000.
module dds_sine_tone_burst
  import dsb_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE_HZ  = 44100,
  parameter int unsigned SINE_TABLE_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AMP_W-1:0] cfg_wdata_i,
  dsb_stream_if.sink       req_i,
  dsb_stream_if.source     rsp_o
);

  // Phase step floor(hz * 2^32 / rate) is formed as hz times a reciprocal
  // rounded up, scaled by 2^63. With hz below 2^15 the error stays below
  // 2^-16, which is smaller than one step of 1/rate, so the floor is exact.
  // Only the low 63 product bits are kept since the step wraps at 2^32.
  localparam int unsigned STEP_SHIFT = 31;
  localparam int unsigned STEP_PW    = PHASE_W + STEP_SHIFT;
  localparam logic [63:0] STEP_MULT  =
    ((64'd1 << STEP_PW) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ);

  // Sample count floor(ms * rate / 1000) uses the same trick with a single
  // constant ms scale; the error bound ms / 2^27 stays under 1/1000.
  localparam int unsigned CNT_SHIFT = 27;
  localparam int unsigned CNT_PW    = CNT_SHIFT + COUNT_W;
  localparam logic [63:0] CNT_MULT  =
    ((64'(SAMPLE_RATE_HZ) << CNT_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);

  // Request stage.
  logic a_valid_q;
  req_t a_req_q;

  // Tone state.
  logic [PHASE_W-1:0] phase_acc_q,    phase_acc_d;
  logic [PHASE_W-1:0] phase_step_q,   phase_step_d;
  logic [COUNT_W-1:0] samples_left_q, samples_left_d;
  logic               silent_q,       silent_d;
  logic [AMP_W-1:0]   amp_q;

  // Response stage.
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  logic a_fire;
  logic is_start;
  logic emit;

  logic [STEP_PW-1:0]  step_prod;
  logic [CNT_PW-1:0]   cnt_prod;
  logic [AMP_W-1:0]    unit_mag;
  logic                unit_neg;
  logic [2*AMP_W-1:0]  scaled_prod;
  logic [SMP_W-1:0]    mag_ext;
  logic [SMP_W-1:0]    sample_bits;

  // The request stage empties whenever the response stage has room; starts
  // and idle ticks also wait for that, which keeps the control simple and
  // still allows one request per cycle.
  assign a_fire    = a_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !a_valid_q || a_fire;
  assign is_start  = (a_req_q.command == CMD_START);
  assign emit      = a_fire && !is_start && (samples_left_q != '0);

  // Start command arithmetic: two constant-coefficient multiplies in parallel.
  assign step_prod = STEP_PW'(a_req_q.tone_hz) * STEP_MULT[STEP_PW-1:0];
  assign cnt_prod  = CNT_PW'(a_req_q.duration_ms) * CNT_MULT[CNT_PW-1:0];

  // Sine lookup uses the phase before it advances.
  dsb_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .index_i    (phase_acc_q[PHASE_W-1 -: SINE_TABLE_BITS]),
    .mag_o      (unit_mag),
    .negative_o (unit_neg)
  );

  // Scaling truncates the magnitude, then the sign is applied, so the
  // result rounds toward zero.
  assign scaled_prod = (2*AMP_W)'(unit_mag) * (2*AMP_W)'(amp_q);
  assign mag_ext     = {1'b0, scaled_prod[2*AMP_W-1 -: AMP_W]};
  assign sample_bits = silent_q ? '0 : (unit_neg ? (~mag_ext + 1'b1) : mag_ext);

  always_comb begin
    phase_acc_d    = phase_acc_q;
    phase_step_d   = phase_step_q;
    samples_left_d = samples_left_q;
    silent_d       = silent_q;
    if (a_fire && is_start) begin
      phase_step_d   = step_prod[STEP_SHIFT +: PHASE_W];
      phase_acc_d    = '0;
      samples_left_d = cnt_prod[CNT_SHIFT +: COUNT_W];
      silent_d       = (a_req_q.tone_hz == '0);
    end else if (emit) begin
      phase_acc_d    = phase_acc_q + phase_step_q;
      samples_left_d = samples_left_q - 1'b1;
    end
  end

  always_comb begin
    rsp_d.sample = $signed(sample_bits);
    rsp_d.active = 1'b1;
    rsp_d.last   = (samples_left_q == COUNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q      <= 1'b0;
      phase_acc_q    <= '0;
      phase_step_q   <= '0;
      samples_left_q <= '0;
      silent_q       <= 1'b0;
      amp_q          <= AMP_RESET;
      rsp_valid_q    <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        a_valid_q <= 1'b1;
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      phase_acc_q    <= phase_acc_d;
      phase_step_q   <= phase_step_d;
      samples_left_q <= samples_left_d;
      silent_q       <= silent_d;
      // The user must write the amplitude only while the block is idle; the block itself does not enforce it.
      if (cfg_we_i) begin
        amp_q <= cfg_wdata_i;
      end
      if (emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      a_req_q <= req_i.payload;
    end
    if (emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

>>> rtl/core/dsb_sine_rom.sv
module dsb_sine_rom
  import dsb_pkg::*;
#(
  parameter int unsigned TABLE_BITS = 8
) (
  input  logic [TABLE_BITS-1:0] index_i,
  output logic [AMP_W-1:0]      mag_o,
  output logic                  negative_o
);

  localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);

  logic [AMP_W-1:0]      lut [QUARTER+1];
  logic [1:0]            quad;
  logic [TABLE_BITS-3:0] offset;
  logic [TABLE_BITS-2:0] folded;

  for (genvar k = 0; k <= QUARTER; k++) begin : g_lut
    localparam logic [AMP_W-1:0] Entry = quarter_sine(k, TABLE_BITS);
    assign lut[k] = Entry;
  end

  // The second and fourth quadrants read the quarter wave backwards.
  assign quad   = index_i[TABLE_BITS-1 -: 2];
  assign offset = index_i[TABLE_BITS-3:0];
  assign folded = quad[0] ? ((TABLE_BITS-1)'(QUARTER) - {1'b0, offset}) : {1'b0, offset};

  assign mag_o      = lut[folded];
  assign negative_o = quad[1];

endmodule

>>> rtl/core/dsb_checker.sv
module dsb_checker
  import dsb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_payload_i
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response changed while stalled");

  // Every sample delivered belongs to a playing tone or silence period.
  a_rsp_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_payload_i.active)
    else $error("response without active flag");

  // The scaled magnitude never reaches full scale, so the most negative code
  // cannot appear.
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_payload_i.sample != -16'sd32768))
    else $error("sample reached the most negative code");

  // Reset holds the response channel empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_i)
    else $error("response valid during reset");

endmodule

bind dds_sine_tone_burst dsb_checker u_dsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

>>> bench/dds_sine_tone_burst_test.sv
module dds_sine_tone_burst_test;
  import dsb_pkg::*;

  // The block is built with its default audio rate and table size. The
  // predictor below uses the same numbers.
  localparam int unsigned AUDIO_RATE   = 44100;
  localparam int unsigned TABLE_BITS   = 8;
  localparam int unsigned QUARTER      = 1 << (TABLE_BITS - 2);
  localparam logic [63:0] TWO_PI_FIX   = 64'd6746518852;  // 2*pi in unsigned Q3.30
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned ITEM_TARGET  = 1950;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // The scoreboard keeps its own copy of the tone state and the amplitude.
  // Every accepted request is stepped through that state, and each tick that
  // finds a tone playing queues the sample the block must return for it.
  class burst_scoreboard;
    logic [AMP_W-1:0]   amplitude;
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [COUNT_W-1:0] samples_left;
    bit                 silent;
    logic [AMP_W-1:0]   unit_sine [0:QUARTER];
    rsp_t               samples_due [$];
    int unsigned        failures;
    int unsigned        checked;

    function new();
      int m;
      amplitude    = AMP_RESET;
      phase        = '0;
      step         = '0;
      samples_left = '0;
      silent       = 1'b0;
      failures     = 0;
      checked      = 0;
      for (m = 0; m <= QUARTER; m++) begin
        unit_sine[m] = sine_magnitude(m);
      end
    endfunction

    // Quarter-wave magnitude scaled to 32768, from an odd Taylor series in
    // Q2.30 with truncating steps, rounded once at the end and saturated.
    function logic [AMP_W-1:0] sine_magnitude(int unsigned m);
      logic [63:0] x;
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] acc;
      int k;
      x    = (64'(m) * TWO_PI_FIX) >> TABLE_BITS;
      x_sq = (x * x) >> 30;
      term = x;
      acc  = x;
      for (k = 1; k <= 8; k++) begin
        term = ((term * x_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 64'd0;
        end else begin
          acc = acc + term;
        end
      end
      acc = (acc * 64'd32768 + (64'd1 << 29)) >> 30;
      return (acc > 64'd32767) ? 15'h7FFF : acc[AMP_W-1:0];
    endfunction

    function void note_request(req_t rq);
      logic [63:0]           wide;
      logic [TABLE_BITS-1:0] idx;
      logic [1:0]            quad;
      int unsigned           m;
      logic [2*AMP_W-1:0]    prod;
      logic [SMP_W-1:0]      value;
      rsp_t                  rs;
      if (rq.command == CMD_START) begin
        wide         = (64'(rq.tone_hz) << 32) / 64'(AUDIO_RATE);
        step         = wide[PHASE_W-1:0];
        phase        = '0;
        wide         = (64'(rq.duration_ms) * 64'(AUDIO_RATE)) / 64'(MS_PER_S);
        samples_left = wide[COUNT_W-1:0];
        silent       = (rq.tone_hz == '0);
      end else if (samples_left != '0) begin
        // The table is read with the phase as it stood before this tick.
        idx   = phase[PHASE_W-1 -: TABLE_BITS];
        quad  = idx[TABLE_BITS-1 -: 2];
        value = '0;
        if (!silent) begin
          m     = quad[0] ? QUARTER - idx[TABLE_BITS-3:0] : idx[TABLE_BITS-3:0];
          prod  = unit_sine[m] * amplitude;
          value = {1'b0, prod[2*AMP_W-1 -: AMP_W]};
          if (quad[1]) begin
            value = -value;
          end
        end
        phase        = phase + step;
        samples_left = samples_left - 1'b1;
        rs.sample    = value;
        rs.active    = 1'b1;
        rs.last      = (samples_left == '0);
        samples_due.push_back(rs);
      end
    endfunction

    function void check_sample(rsp_t got);
      rsp_t want;
      if (samples_due.size() == 0) begin
        $error("sample %0d arrived with none expected", got.sample);
        failures++;
        return;
      end
      want = samples_due.pop_front();
      checked++;
      if (got.sample !== want.sample) begin
        $error("sample: expected %0d, actual %0d", want.sample, got.sample);
        failures++;
      end
      if (got.active !== want.active) begin
        $error("active: expected %0b, actual %0b", want.active, got.active);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return samples_due.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [AMP_W-1:0] cfg_wdata_i;

  dsb_stream_if #(.payload_t(req_t)) req_if ();
  dsb_stream_if #(.payload_t(rsp_t)) rsp_if ();

  burst_scoreboard sb;
  int unsigned     items_sent;
  int unsigned     cycle_count;
  bit              long_hold_done;

  dds_sine_tone_burst #(
    .SAMPLE_RATE_HZ  (AUDIO_RATE),
    .SINE_TABLE_BITS (TABLE_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if.sink),
    .rsp_o       (rsp_if.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A run that takes far longer than the slowest legal one means the block
  // has lost or withheld a sample, so it is ended as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Every sample the block hands over is compared with the oldest one the
  // scoreboard has queued. Values are sampled at the edge, before any
  // nonblocking update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_sample(rsp_if.payload);
    end
  end

  function automatic req_t make_req(cmd_e cmd, int unsigned hz, int unsigned ms);
    req_t rq;
    rq.command     = cmd;
    rq.tone_hz     = HZ_W'(hz);
    rq.duration_ms = MS_W'(ms);
    return rq;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and holds it until the block takes it. Valid stays
  // high on return, so a following request goes out back to back.
  task automatic offer(input req_t rq);
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do begin
      @(posedge clk_i);
    end while (!(req_if.valid && req_if.ready));
    sb.note_request(rq);
    items_sent++;
  endtask

  // Drops valid for a number of cycles, with noise on the payload that the
  // block must not pick up.
  task automatic idle_for(input int unsigned cycles);
    req_if.valid   <= 1'b0;
    req_if.payload <= req_t'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic offer_paced(input req_t rq, input bit gap_free);
    int unsigned gap;
    gap = gap_free ? 0 : pick_gap();
    if (gap > 0) begin
      idle_for(gap);
    end
    offer(rq);
  endtask

  // A tick carries random frequency and duration fields, which it must ignore.
  task automatic offer_tick(input bit gap_free);
    offer_paced(make_req(CMD_TICK, $urandom_range(0, 32767), $urandom_range(0, 65535)),
                gap_free);
  endtask

  // Waits until every queued sample has come back. A start or an idle tick
  // leaves nothing to wait for, so a settling wait follows before the block
  // is taken as idle.
  task automatic settle_block();
    idle_for(1);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_amplitude(input int unsigned amp);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= AMP_W'(amp);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.amplitude = AMP_W'(amp);
  endtask

  // Directed requests, all at the reset amplitude: a tick with no tone, a
  // zero duration, a silent tone, a maximal duration cut short by the next
  // start, a frequency of a quarter of the sample rate that lands on the
  // peaks and zero crossings, the largest frequency the field holds, and the
  // slowest nonzero tone.
  task automatic run_directed();
    int k;
    offer(make_req(CMD_TICK, 32767, 65535));
    offer(make_req(CMD_START, 1000, 0));
    offer_tick(1'b1);
    offer(make_req(CMD_START, 0, 1));
    for (k = 0; k < 3; k++) offer_tick(1'b1);
    offer(make_req(CMD_START, 20000, 65535));
    for (k = 0; k < 3; k++) offer_tick(1'b1);
    offer(make_req(CMD_START, AUDIO_RATE / 4, 1));
    for (k = 0; k < 5; k++) offer_tick(1'b1);
    offer(make_req(CMD_START, 32767, 1));
    for (k = 0; k < 3; k++) offer_tick(1'b1);
    offer(make_req(CMD_START, 1, 1));
    for (k = 0; k < 2; k++) offer_tick(1'b1);
  endtask

  // One tone: a start with random content, then ticks. Most tones are short
  // and played to the end, so that the last flag and the idle ticks after it
  // are seen; some are cut off by the next start, including the long ones.
  task automatic play_burst();
    int unsigned r;
    int unsigned hz;
    int unsigned ms;
    int unsigned samples;
    int unsigned ticks;
    bit          gap_free;
    int          k;
    gap_free = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      hz = 0;
    end else if (r < 25) begin
      hz = $urandom_range(0, 32767);
    end else if (r < 32) begin
      hz = $urandom_range(20000, 32767);
    end else begin
      hz = $urandom_range(1, 20000);
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      ms = 0;
    end else if (r < 12) begin
      ms = $urandom_range(0, 65535);
    end else begin
      ms = $urandom_range(1, 3);
    end
    samples = (ms * AUDIO_RATE) / MS_PER_S;
    if (samples > 200 || $urandom_range(0, 99) < 20) begin
      ticks = $urandom_range(0, (samples < 60) ? samples : 60);
    end else begin
      ticks = samples + $urandom_range(0, 3);
    end
    offer_paced(make_req(CMD_START, hz, ms), gap_free);
    for (k = 0; k < ticks; k++) begin
      offer_tick(gap_free);
    end
  endtask

  // The sample side stalls at random, with long stretches of steady ready in
  // between. Once, well into the run, it holds off for a long time while the
  // request side keeps offering ticks, so the block backs up and stops
  // taking requests.
  initial begin : sample_sink
    int unsigned stall;
    int unsigned run;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && sb.checked >= 400) begin
        long_hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned amp_plan [PHASES];
    int unsigned phase_goal;
    int          p;
    sb             = new();
    items_sent     = 0;
    cycle_count    = 0;
    long_hold_done = 1'b0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random tones under a series of amplitudes, the extremes among them.
    // The amplitude only changes once the block has gone quiet.
    amp_plan = '{32767, 0, 1, $urandom_range(2, 32766), $urandom_range(0, 32767)};
    for (p = 0; p < PHASES; p++) begin
      settle_block();
      write_amplitude(amp_plan[p]);
      phase_goal = items_sent + ITEM_TARGET / PHASES;
      while (items_sent < phase_goal) begin
        play_burst();
      end
    end
    settle_block();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
